[src/trle_pkg.sv]
package trle_pkg;

  localparam logic [4:0] HDR_ID_LEN   = 5'd0;
  localparam logic [4:0] HDR_CMAP     = 5'd1;
  localparam logic [4:0] HDR_TYPE     = 5'd2;
  localparam logic [4:0] HDR_W_LO     = 5'd12;
  localparam logic [4:0] HDR_W_HI     = 5'd13;
  localparam logic [4:0] HDR_H_LO     = 5'd14;
  localparam logic [4:0] HDR_H_HI     = 5'd15;
  localparam logic [4:0] HDR_BPP      = 5'd16;
  localparam logic [4:0] HDR_LAST     = 5'd17;

  localparam logic [7:0] TYPE_RAW     = 8'd2;
  localparam logic [7:0] TYPE_RLE     = 8'd10;
  localparam logic [7:0] BPP_24       = 8'd24;
  localparam logic [7:0] BPP_32       = 8'd32;
  localparam logic [7:0] PKT_REP_BIAS = 8'd127;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  typedef struct packed {
    logic        kind;
    logic        has_alpha;
    logic [23:0] color;
    logic [7:0]  alpha_byte;
    logic [7:0]  count;
    logic        last;
    logic [15:0] width;
    logic [15:0] height;
  } trle_item_t;

endpackage

[src/trle_front.sv]
module trle_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic                start_of_file_i,
  output logic                item_valid_o,
  output trle_pkg::trle_item_t item_o
);
  import trle_pkg::*;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_IDSKIP = 3'd1;
  localparam logic [2:0] PH_PACKET = 3'd2;
  localparam logic [2:0] PH_PIXEL  = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;
  localparam logic [2:0] PH_REJECT = 3'd5;

  logic [2:0]  phase_q, phase_d, phase_b;
  logic [4:0]  hidx_q, hidx_d, hidx_b;
  logic [7:0]  idskip_q, idskip_d, idskip_b;
  logic        is_rle_q, is_rle_d, is_rle_b;
  logic        has_alpha_q, has_alpha_d, has_alpha_b;
  logic [15:0] width_q, width_d, width_b;
  logic [15:0] height_q, height_d, height_b;
  logic [31:0] pleft_q, pleft_d, pleft_b;
  logic        rep_q, rep_d, rep_b;
  logic [7:0]  pkt_q, pkt_d, pkt_b;
  logic [1:0]  bip_q, bip_d, bip_b;
  logic [23:0] held_q, held_d, held_b;
  logic        bad_q, bad_d, bad_b;
  logic [31:0] area;
  logic [7:0]  cnt;
  logic [31:0] pleft_new;
  logic [23:0] color;

  assign area = {16'd0, width_b} * {16'd0, height_b};

  always_comb begin
    phase_b     = start_of_file_i ? PH_HEADER : phase_q;
    hidx_b      = start_of_file_i ? 5'd0 : hidx_q;
    idskip_b    = start_of_file_i ? 8'd0 : idskip_q;
    is_rle_b    = start_of_file_i ? 1'b0 : is_rle_q;
    has_alpha_b = start_of_file_i ? 1'b0 : has_alpha_q;
    width_b     = start_of_file_i ? 16'd0 : width_q;
    height_b    = start_of_file_i ? 16'd0 : height_q;
    pleft_b     = start_of_file_i ? 32'd0 : pleft_q;
    rep_b       = start_of_file_i ? 1'b0 : rep_q;
    pkt_b       = start_of_file_i ? 8'd0 : pkt_q;
    bip_b       = start_of_file_i ? 2'd0 : bip_q;
    held_b      = start_of_file_i ? 24'd0 : held_q;
    bad_b       = start_of_file_i ? 1'b0 : bad_q;

    phase_d     = phase_b;
    hidx_d      = hidx_b;
    idskip_d    = idskip_b;
    is_rle_d    = is_rle_b;
    has_alpha_d = has_alpha_b;
    width_d     = width_b;
    height_d    = height_b;
    pleft_d     = pleft_b;
    rep_d       = rep_b;
    pkt_d       = pkt_b;
    bip_d       = bip_b;
    held_d      = held_b;
    bad_d       = bad_b;

    cnt       = 8'd1;
    pleft_new = pleft_b;
    color     = held_b;

    item_valid_o = 1'b0;
    item_o       = '0;

    case (phase_b)
      PH_HEADER: begin
        case (hidx_b)
          HDR_ID_LEN: idskip_d = data_byte_i;
          HDR_CMAP: begin
            if (data_byte_i != 8'd0) bad_d = 1'b1;
          end
          HDR_TYPE: begin
            if (data_byte_i == TYPE_RAW) is_rle_d = 1'b0;
            else if (data_byte_i == TYPE_RLE) is_rle_d = 1'b1;
            else bad_d = 1'b1;
          end
          HDR_W_LO: width_d = {width_b[15:8], data_byte_i};
          HDR_W_HI: width_d = {data_byte_i, width_b[7:0]};
          HDR_H_LO: height_d = {height_b[15:8], data_byte_i};
          HDR_H_HI: height_d = {data_byte_i, height_b[7:0]};
          HDR_BPP: begin
            if (data_byte_i == BPP_32) has_alpha_d = 1'b1;
            else if (data_byte_i == BPP_24) has_alpha_d = 1'b0;
            else bad_d = 1'b1;
          end
          default: ;
        endcase
        if (hidx_b < HDR_LAST) begin
          hidx_d = hidx_b + 5'd1;
        end else begin
          hidx_d = 5'd0;
          if (bad_b) begin
            phase_d      = PH_REJECT;
            item_valid_o = 1'b1;
            item_o.kind  = KIND_REJECT;
            item_o.count = 8'd0;
            item_o.width = width_b;
            item_o.height = height_b;
          end else begin
            pleft_d = area;
            if (width_b == 16'd0 || height_b == 16'd0) begin
              phase_d = PH_DONE;
            end else if (idskip_b != 8'd0) begin
              phase_d = PH_IDSKIP;
            end else begin
              bip_d   = 2'd0;
              pkt_d   = 8'd0;
              rep_d   = 1'b0;
              phase_d = is_rle_b ? PH_PACKET : PH_PIXEL;
            end
          end
        end
      end
      PH_IDSKIP: begin
        idskip_d = idskip_b - 8'd1;
        if (idskip_d == 8'd0) begin
          bip_d   = 2'd0;
          pkt_d   = 8'd0;
          rep_d   = 1'b0;
          phase_d = is_rle_b ? PH_PACKET : PH_PIXEL;
        end
      end
      PH_PACKET: begin
        if (!data_byte_i[7]) begin
          rep_d = 1'b0;
          pkt_d = data_byte_i + 8'd1;
        end else begin
          rep_d = 1'b1;
          pkt_d = data_byte_i - PKT_REP_BIAS;
        end
        bip_d   = 2'd0;
        held_d  = 24'd0;
        phase_d = PH_PIXEL;
      end
      PH_PIXEL: begin
        if (bip_b < 2'd2 || (bip_b == 2'd2 && has_alpha_b)) begin
          case (bip_b)
            2'd0:    held_d = held_b | {16'd0, data_byte_i};
            2'd1:    held_d = held_b | {8'd0, data_byte_i, 8'd0};
            default: held_d = held_b | {data_byte_i, 16'd0};
          endcase
          bip_d = bip_b + 2'd1;
        end else begin
          if (bip_b == 2'd2) color = held_b | {data_byte_i, 16'd0};
          held_d = 24'd0;
          bip_d  = 2'd0;
          if (is_rle_b && rep_b) cnt = pkt_b;
          if ({24'd0, cnt} > pleft_b) cnt = pleft_b[7:0];
          pleft_new = pleft_b - {24'd0, cnt};
          pleft_d   = pleft_new;
          if (pleft_new == 32'd0) begin
            phase_d = PH_DONE;
          end else if (is_rle_b) begin
            if (rep_b) begin
              phase_d = PH_PACKET;
            end else begin
              pkt_d = pkt_b - 8'd1;
              if (pkt_d == 8'd0) phase_d = PH_PACKET;
            end
          end
          item_valid_o      = 1'b1;
          item_o.kind       = KIND_PIXEL;
          item_o.has_alpha  = has_alpha_b;
          item_o.color      = color;
          item_o.alpha_byte = data_byte_i;
          item_o.count      = cnt;
          item_o.last       = (pleft_new == 32'd0);
          item_o.width      = width_b;
          item_o.height     = height_b;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      hidx_q      <= 5'd0;
      idskip_q    <= 8'd0;
      is_rle_q    <= 1'b0;
      has_alpha_q <= 1'b0;
      width_q     <= 16'd0;
      height_q    <= 16'd0;
      pleft_q     <= 32'd0;
      rep_q       <= 1'b0;
      pkt_q       <= 8'd0;
      bip_q       <= 2'd0;
      held_q      <= 24'd0;
      bad_q       <= 1'b0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      hidx_q      <= hidx_d;
      idskip_q    <= idskip_d;
      is_rle_q    <= is_rle_d;
      has_alpha_q <= has_alpha_d;
      width_q     <= width_d;
      height_q    <= height_d;
      pleft_q     <= pleft_d;
      rep_q       <= rep_d;
      pkt_q       <= pkt_d;
      bip_q       <= bip_d;
      held_q      <= held_d;
      bad_q       <= bad_d;
    end
  end

endmodule

[src/trle_queue.sv]
module trle_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  trle_pkg::trle_item_t wr_item_i,
  output logic                 full_o,
  output logic                 empty_o,
  input  logic                 rd_en_i,
  output trle_pkg::trle_item_t rd_item_o
);
  import trle_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  trle_item_t    mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_wr, do_rd;

  assign full_o    = (cnt_q == FULL_CNT);
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      if (do_rd) rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
      else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

[src/trle_back.sv]
module trle_back (
  input  trle_pkg::trle_item_t item_i,
  output logic [7:0]           red_o,
  output logic [7:0]           green_o,
  output logic [7:0]           blue_o,
  output logic [7:0]           alpha_o,
  output logic [7:0]           repeat_count_o,
  output logic                 last_run_o,
  output logic                 result_kind_o,
  output logic [15:0]          image_width_o,
  output logic [15:0]          image_height_o
);
  import trle_pkg::*;

  logic pix;

  assign pix            = (item_i.kind == KIND_PIXEL);
  assign blue_o         = pix ? item_i.color[7:0]   : 8'd0;
  assign green_o        = pix ? item_i.color[15:8]  : 8'd0;
  assign red_o          = pix ? item_i.color[23:16] : 8'd0;
  assign alpha_o        = !pix ? 8'd0 :
                          (item_i.has_alpha ? item_i.alpha_byte : ALPHA_OPAQUE);
  assign repeat_count_o = pix ? item_i.count : 8'd0;
  assign last_run_o     = pix && item_i.last;
  assign result_kind_o  = item_i.kind;
  assign image_width_o  = item_i.width;
  assign image_height_o = item_i.height;

endmodule

[src/tga_rle_pixel_decoder.sv]
// Channel   Handshake      Payload
// input     push / full    data_byte_i, start_of_file_i
// result    empty / pop    red_o .. image_height_o
//
// One file byte is accepted every cycle while the result queue has room.
// The parser updates its counters in the cycle a byte is taken and places a result
// in a QUEUE_DEPTH-entry queue, whose head drives the result ports directly.
// The byte stream stalls only when the queue is full; after reset the parser
// expects header byte 0.
module tga_rle_pixel_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_file_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic [7:0]  repeat_count_o,
  output logic        last_run_o,
  output logic        result_kind_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o
);
  import trle_pkg::*;

  logic       accept;
  logic       item_valid;
  trle_item_t item, head;

  assign accept = push && !full;

  trle_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .start_of_file_i (start_of_file_i),
    .item_valid_o    (item_valid),
    .item_o          (item)
  );

  trle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept && item_valid),
    .wr_item_i (item),
    .full_o    (full),
    .empty_o   (empty),
    .rd_en_i   (pop),
    .rd_item_o (head)
  );

  trle_back u_back (
    .item_i         (head),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .alpha_o        (alpha_o),
    .repeat_count_o (repeat_count_o),
    .last_run_o     (last_run_o),
    .result_kind_o  (result_kind_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o)
  );

endmodule

[dv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import trle_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  typedef enum logic [2:0] {
    PH_HDR, PH_SKIP, PH_PKT, PH_PIX, PH_DONE, PH_REJ
  } dec_phase_e;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  count;
    logic        last;
    logic        kind;
    logic [15:0] width;
    logic [15:0] height;
  } pix_run_t;

  typedef struct packed {
    logic [7:0] data;
    logic       sof;
    logic       typed;
    pix_run_t   res;
  } file_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte_i = 8'd0;
  logic        start_of_file_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic [7:0]  alpha_o;
  logic [7:0]  repeat_count_o;
  logic        last_run_o;
  logic        result_kind_o;
  logic [15:0] image_width_o;
  logic [15:0] image_height_o;

  tga_rle_pixel_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .data_byte_i     (data_byte_i),
    .start_of_file_i (start_of_file_i),
    .empty           (empty),
    .pop             (pop),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .alpha_o         (alpha_o),
    .repeat_count_o  (repeat_count_o),
    .last_run_o      (last_run_o),
    .result_kind_o   (result_kind_o),
    .image_width_o   (image_width_o),
    .image_height_o  (image_height_o)
  );

  always #5 clk_i = ~clk_i;

  // A header with an unsupported image type and the largest size, entered
  // right after reset without a start-of-file flag, then two ignored bytes.
  file_byte_t dir_tab [20] = '{
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h03, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h18, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b1,
      '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, KIND_REJECT, 16'hFFFF, 16'hFFFF}},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0}
  };

  file_byte_t file_bytes [$];
  pix_run_t   pending_runs [$];
  int         errors = 0;

  dec_phase_e  ph = PH_HDR;
  logic [4:0]  hidx = '0;
  logic [7:0]  id_left = '0;
  logic        rle = 1'b0;
  logic        alp = 1'b0;
  logic [15:0] wreg = '0;
  logic [15:0] hreg = '0;
  logic [31:0] pleft = '0;
  logic        prep = 1'b0;
  logic [7:0]  pkt_left = '0;
  logic [1:0]  bip = '0;
  logic [23:0] held = '0;
  logic        bad = 1'b0;

  logic       full_s;
  logic       empty_s;
  pix_run_t   seen_run;

  function automatic logic [7:0] rnd_byte();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic put_byte(input logic [7:0] d, input logic s);
    file_bytes.push_back('{d, s, 1'b0, '0});
  endtask

  task automatic start_pixel_data();
    bip = '0;
    pkt_left = '0;
    prep = 1'b0;
    ph = rle ? PH_PKT : PH_PIX;
  endtask

  task automatic decode_byte(input logic [7:0] d, input logic sof, output logic got,
                             output pix_run_t run);
    logic [7:0] cnt;
    logic [7:0] a;
    logic       lst;
    got = 1'b0;
    run = '0;
    if (sof) begin
      ph = PH_HDR;
      hidx = '0;
      id_left = '0;
      rle = 1'b0;
      alp = 1'b0;
      wreg = '0;
      hreg = '0;
      pleft = '0;
      prep = 1'b0;
      pkt_left = '0;
      bip = '0;
      held = '0;
      bad = 1'b0;
    end
    case (ph)
      PH_HDR: begin
        case (hidx)
          HDR_ID_LEN: id_left = d;
          HDR_CMAP: if (d != 8'd0) bad = 1'b1;
          HDR_TYPE: begin
            if (d == TYPE_RAW) rle = 1'b0;
            else if (d == TYPE_RLE) rle = 1'b1;
            else bad = 1'b1;
          end
          HDR_W_LO: wreg[7:0] = d;
          HDR_W_HI: wreg[15:8] = d;
          HDR_H_LO: hreg[7:0] = d;
          HDR_H_HI: hreg[15:8] = d;
          HDR_BPP: begin
            if (d == BPP_32) alp = 1'b1;
            else if (d == BPP_24) alp = 1'b0;
            else bad = 1'b1;
          end
          default: ;
        endcase
        if (hidx != HDR_LAST) begin
          hidx = hidx + 5'd1;
        end else begin
          hidx = '0;
          if (bad) begin
            ph = PH_REJ;
            got = 1'b1;
            run.kind = KIND_REJECT;
            run.width = wreg;
            run.height = hreg;
          end else begin
            pleft = 32'(wreg) * 32'(hreg);
            if (pleft == 32'd0) ph = PH_DONE;
            else if (id_left != 8'd0) ph = PH_SKIP;
            else start_pixel_data();
          end
        end
      end
      PH_SKIP: begin
        id_left = id_left - 8'd1;
        if (id_left == 8'd0) start_pixel_data();
      end
      PH_PKT: begin
        if (d < 8'd128) begin
          prep = 1'b0;
          pkt_left = d + 8'd1;
        end else begin
          prep = 1'b1;
          pkt_left = d - PKT_REP_BIAS;
        end
        bip = '0;
        held = '0;
        ph = PH_PIX;
      end
      PH_PIX: begin
        if (bip < 2'd2 || (bip == 2'd2 && alp)) begin
          held = held | (24'(d) << (8 * bip));
          bip = bip + 2'd1;
        end else begin
          if (bip == 2'd2) begin
            held[23:16] = d;
            a = ALPHA_OPAQUE;
          end else begin
            a = d;
          end
          run.blue = held[7:0];
          run.green = held[15:8];
          run.red = held[23:16];
          held = '0;
          bip = '0;
          cnt = (rle && prep) ? pkt_left : 8'd1;
          if ({24'd0, cnt} > pleft) cnt = pleft[7:0];
          pleft = pleft - {24'd0, cnt};
          lst = (pleft == 32'd0);
          if (lst) begin
            ph = PH_DONE;
          end else if (rle) begin
            if (prep) begin
              ph = PH_PKT;
            end else begin
              pkt_left = pkt_left - 8'd1;
              if (pkt_left == 8'd0) ph = PH_PKT;
            end
          end
          got = 1'b1;
          run.alpha = a;
          run.count = cnt;
          run.last = lst;
          run.kind = KIND_PIXEL;
          run.width = wreg;
          run.height = hreg;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(negedge clk_i) begin
    full_s = full;
    empty_s = empty;
    seen_run = '{red_o, green_o, blue_o, alpha_o, repeat_count_o, last_run_o,
                 result_kind_o, image_width_o, image_height_o};
  end

  file_byte_t cur_byte = '0;
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk_i) begin
    file_byte_t nxt;
    logic       nxt_push;
    logic       got;
    pix_run_t   run;
    if (rst_ni) begin
      nxt = cur_byte;
      nxt_push = push;
      if (push && !full_s) begin
        decode_byte(cur_byte.data, cur_byte.sof, got, run);
        if (cur_byte.typed) pending_runs.push_back(cur_byte.res);
        else if (got) pending_runs.push_back(run);
        nxt_push = 1'b0;
      end
      if (!nxt_push) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (file_bytes.size() > 0) begin
          nxt = file_bytes.pop_front();
          nxt_push = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      cur_byte <= nxt;
      push <= nxt_push;
      data_byte_i <= nxt.data;
      start_of_file_i <= nxt.sof;
    end
  end

  int pop_mode = 0;
  int mode_left = 0;
  int cyc = 0;

  always @(posedge clk_i) begin
    pix_run_t want;
    logic     nxt_pop;
    if (rst_ni) begin
      if (pop && !empty_s) begin
        if (pending_runs.size() == 0) begin
          $display("%0t: result expected none actual %h", $time, seen_run);
          errors++;
        end else begin
          want = pending_runs.pop_front();
          check_field("red", 16'(want.red), 16'(seen_run.red));
          check_field("green", 16'(want.green), 16'(seen_run.green));
          check_field("blue", 16'(want.blue), 16'(seen_run.blue));
          check_field("alpha", 16'(want.alpha), 16'(seen_run.alpha));
          check_field("repeat_count", 16'(want.count), 16'(seen_run.count));
          check_field("last_run", 16'(want.last), 16'(seen_run.last));
          check_field("result_kind", 16'(want.kind), 16'(seen_run.kind));
          check_field("image_width", want.width, seen_run.width);
          check_field("image_height", want.height, seen_run.height);
        end
      end
      if (mode_left == 0) begin
        pop_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      cyc++;
      case (pop_mode)
        0: nxt_pop = 1'b1;
        1: nxt_pop = 1'($urandom_range(0, 1));
        2: nxt_pop = ($urandom_range(0, 7) == 0);
        default: nxt_pop = ((cyc % 8) < 3);
      endcase
      pop <= nxt_pop;
    end
  end

  int quiet = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full_s) || (pop && !empty_s)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int         sel;
    int         w;
    int         h;
    int         idl;
    int         cnt;
    int         nb;
    int         trunc;
    int         nbp;
    int         junk;
    int         k;
    longint     npix;
    logic [7:0] typ;
    logic [7:0] bpp;
    logic [7:0] cmap;
    logic       big;
    logic       bad_img;

    foreach (dir_tab[i]) file_bytes.push_back(dir_tab[i]);

    junk = 2;
    while (file_bytes.size() - junk < 820) begin
      sel = $urandom_range(0, 99);
      cmap = 8'd0;
      typ = $urandom_range(0, 1) ? TYPE_RLE : TYPE_RAW;
      bpp = $urandom_range(0, 1) ? BPP_32 : BPP_24;
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 5);
      trunc = 1 << 30;
      big = 1'b0;
      if ($urandom_range(0, 9) == 0) idl = $urandom_range(4, 255);
      else idl = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);

      if (sel >= 93) begin
        put_byte(rnd_byte(), 1'b1);
        repeat ($urandom_range(10, 40)) put_byte(rnd_byte(), 1'b0);
        continue;
      end
      if (sel < 60) begin
        if ($urandom_range(0, 9) == 0) trunc = $urandom_range(0, 20);
      end else if (sel < 70) begin
        big = 1'b1;
        typ = TYPE_RLE;
        w = $urandom_range(100, 1000);
        h = $urandom_range(1, 3);
      end else if (sel < 78) begin
        if ($urandom_range(0, 1)) begin
          w = 0;
          h = $urandom_range(0, 1) ? 65535 : $urandom_range(0, 65535);
        end else begin
          h = 0;
          w = $urandom_range(0, 1) ? 65535 : $urandom_range(0, 65535);
        end
      end else if (sel < 88) begin
        w = $urandom_range(0, 65535);
        h = $urandom_range(0, 65535);
        case ($urandom_range(0, 2))
          0: cmap = 8'($urandom_range(1, 255));
          1: do typ = 8'($urandom_range(0, 255)); while (typ == TYPE_RAW || typ == TYPE_RLE);
          default: do bpp = 8'($urandom_range(0, 255)); while (bpp == BPP_24 || bpp == BPP_32);
        endcase
      end else begin
        w = $urandom_range(0, 1) ? 65535 : $urandom_range(30000, 65535);
        h = $urandom_range(0, 1) ? 65535 : $urandom_range(30000, 65535);
        trunc = $urandom_range(5, 60);
      end

      put_byte(8'(idl), 1'b1);
      put_byte(cmap, 1'b0);
      put_byte(typ, 1'b0);
      repeat (9) put_byte(rnd_byte(), 1'b0);
      put_byte(w[7:0], 1'b0);
      put_byte(w[15:8], 1'b0);
      put_byte(h[7:0], 1'b0);
      put_byte(h[15:8], 1'b0);
      put_byte(bpp, 1'b0);
      put_byte(rnd_byte(), 1'b0);

      bad_img = (cmap != 8'd0) || (typ != TYPE_RAW && typ != TYPE_RLE) ||
                (bpp != BPP_24 && bpp != BPP_32);
      if (bad_img || w == 0 || h == 0) begin
        cnt = $urandom_range(0, 6);
        repeat (cnt) put_byte(rnd_byte(), 1'b0);
        junk += cnt;
        continue;
      end

      repeat (idl) put_byte(rnd_byte(), 1'b0);
      npix = longint'(w) * longint'(h);
      nbp = (bpp == BPP_32) ? 4 : 3;
      nb = 0;
      while (npix > 0 && nb < trunc) begin
        if (typ == TYPE_RAW) begin
          repeat (nbp) put_byte(rnd_byte(), 1'b0);
          npix--;
          nb += nbp;
        end else if ($urandom_range(0, 99) < (big ? 85 : 50)) begin
          if (big) cnt = $urandom_range(32, 128);
          else if ($urandom_range(0, 3) == 0) cnt = $urandom_range(0, 1) ? 128 : $urandom_range(1, 128);
          else cnt = $urandom_range(1, 4);
          put_byte(8'(cnt + 127), 1'b0);
          repeat (nbp) put_byte(rnd_byte(), 1'b0);
          npix -= (cnt < npix) ? cnt : npix;
          nb += 1 + nbp;
        end else begin
          if (!big && $urandom_range(0, 3) == 0) cnt = $urandom_range(0, 1) ? 128 : $urandom_range(1, 128);
          else cnt = $urandom_range(1, 4);
          put_byte(8'(cnt - 1), 1'b0);
          nb++;
          for (k = 0; k < cnt && npix > 0 && nb < trunc; k++) begin
            repeat (nbp) put_byte(rnd_byte(), 1'b0);
            npix--;
            nb += nbp;
          end
        end
      end
      if (npix == 0) begin
        cnt = $urandom_range(0, 3) == 0 ? $urandom_range(1, 5) : 0;
        repeat (cnt) put_byte(rnd_byte(), 1'b0);
        junk += cnt;
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (file_bytes.size() != 0 || push || pending_runs.size() != 0);
    repeat (20) @(posedge clk_i);

    if (errors == 0 && pending_runs.size() == 0 && empty) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
